FILE: rtl/rrlr_pkg.sv
// rrlr_pkg: shared constants for the receive ring line reader.
// No dependencies; imported by the top level and its checker.
`timescale 1ns / 1ps

package rrlr_pkg;

   localparam int DATA_W = 8;
   localparam int LEN_W  = 7;
   localparam int CNT_W  = 6;

   // request opcodes
   localparam logic OP_RX_BYTE   = 1'b0;
   localparam logic OP_READ_LINE = 1'b1;

   localparam logic [DATA_W-1:0] NEWLINE_CODE = 8'h0A;

endpackage

FILE: rtl/rrlr_ram.sv
// rrlr_ram: generic single-write, single-read synchronous RAM.
// Registered read data. No dependencies.
`timescale 1ns / 1ps

module rrlr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/rx_ring_line_reader_unit.sv
// rx_ring_line_reader_unit: receive byte ring with bounded line read.
// Depends on rrlr_pkg and rrlr_ram.
`timescale 1ns / 1ps
//
//  channel   | ports                                  | handshake
//  ----------+----------------------------------------+------------------------------
//  request   | req_op, req_rx_byte, req_max_len       | beat when start && !busy
//  response  | rsp_data_byte, rsp_last, rsp_count,    | beat when rsp_valid, one cycle,
//            | rsp_got_data                           | no back-pressure
//
//  A received-byte beat is written into the ring RAM at the accepting edge, unless
//  the ring is full and it is dropped; busy never rises for it, so the next beat
//  can follow in the next cycle. A line-read beat raises busy and pops the bytes
//  one at a time, each through S_ISSUE (RAM read) and then S_DATA (compare and
//  emit); busy stays high until the state that issues the terminator, whether the
//  read ends on a newline, on the limit or on an empty ring. The registered RAM
//  read sets that pace. Reset is synchronous and clears pointers and control; the
//  RAM needs no clearing pass. The response side cannot stall: each response beat
//  is shown for exactly one cycle from an output register.

module rx_ring_line_reader_unit #(
   parameter int RING_DEPTH = 256,
   parameter int MAX_READ   = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   // request
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_op,
   input  logic [rrlr_pkg::DATA_W-1:0]  req_rx_byte,
   input  logic [rrlr_pkg::LEN_W-1:0]   req_max_len,
   // response
   output logic                         rsp_valid,
   output logic [rrlr_pkg::DATA_W-1:0]  rsp_data_byte,
   output logic                         rsp_last,
   output logic [rrlr_pkg::CNT_W-1:0]   rsp_count,
   output logic                         rsp_got_data
);

   import rrlr_pkg::*;

   localparam int PTR_W = $clog2(RING_DEPTH);

   typedef enum logic [1:0] {
      S_IDLE,
      S_ISSUE,   // check stop conditions, launch RAM read
      S_DATA,    // RAM data back: emit byte, advance read pointer
      S_TERM     // newline seen: emit terminator
   } state_type;

   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] n;
      if (p == PTR_W'(RING_DEPTH - 1)) begin
         n = '0;
      end else begin
         n = p + PTR_W'(1);
      end
      return n;
   endfunction

   state_type            state_ff, state_in;
   logic [PTR_W-1:0]     wp_ff, wp_in;
   logic [PTR_W-1:0]     rp_ff, rp_in;
   logic [CNT_W-1:0]     popped_ff, popped_in;
   logic [CNT_W-1:0]     budget_ff, budget_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]    rsp_data_ff, rsp_data_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic [CNT_W-1:0]     rsp_count_ff, rsp_count_in;
   logic                 rsp_got_ff, rsp_got_in;

   logic                 accept;
   logic                 wr_en;
   logic                 rd_en;
   logic [DATA_W-1:0]    rd_data;
   logic [LEN_W-1:0]     lim;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   // Writes only happen while idle and reads only while busy, so the two
   // RAM ports never touch the same entry in one cycle.
   assign wr_en = accept && (req_op == OP_RX_BYTE) && (ring_next(wp_ff) != rp_ff);

   // saturate the limit, then one slot goes to the terminator
   assign lim = (req_max_len > LEN_W'(MAX_READ)) ? LEN_W'(MAX_READ) : req_max_len;

   rrlr_ram #(
      .WIDTH (DATA_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wp_ff),
      .wr_data (req_rx_byte),
      .rd_en   (rd_en),
      .rd_addr (rp_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      wp_in        = wr_en ? ring_next(wp_ff) : wp_ff;
      rp_in        = rp_ff;
      popped_in    = popped_ff;
      budget_in    = budget_ff;
      rd_en        = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_data_in  = '0;
      rsp_last_in  = 1'b0;
      rsp_count_in = '0;
      rsp_got_in   = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept && (req_op == OP_READ_LINE)) begin
               popped_in = '0;
               budget_in = (lim == '0) ? '0 : CNT_W'(lim - LEN_W'(1));
               state_in  = S_ISSUE;
            end
         end
         S_ISSUE: begin
            if ((rp_ff == wp_ff) || (popped_ff == budget_ff)) begin
               // ring empty or limit reached
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               rsp_count_in = popped_ff;
               rsp_got_in   = (popped_ff != '0);
               state_in     = S_IDLE;
            end else begin
               rd_en    = 1'b1;
               state_in = S_DATA;
            end
         end
         S_DATA: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = rd_data;
            rp_in        = ring_next(rp_ff);
            popped_in    = popped_ff + CNT_W'(1);
            state_in     = (rd_data == NEWLINE_CODE) ? S_TERM : S_ISSUE;
         end
         S_TERM: begin
            rsp_valid_in = 1'b1;
            rsp_last_in  = 1'b1;
            rsp_count_in = popped_ff;
            rsp_got_in   = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wp_ff        <= '0;
         rp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      // payload and per-read counters need no reset
      popped_ff    <= popped_in;
      budget_ff    <= budget_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_count_ff <= rsp_count_in;
      rsp_got_ff   <= rsp_got_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data_byte = rsp_data_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_count     = rsp_count_ff;
   assign rsp_got_data  = rsp_got_ff;

endmodule

FILE: rtl/rrlr_checker.sv
// rrlr_checker: port-level assertions for rx_ring_line_reader_unit.
// Depends on rrlr_pkg; bound to the top level at the end of this file.
`timescale 1ns / 1ps

module rrlr_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic                         req_op,
   input logic                         rsp_valid,
   input logic                         rsp_last,
   input logic [rrlr_pkg::CNT_W-1:0]   rsp_count,
   input logic                         rsp_got_data
);

   import rrlr_pkg::*;

   // a received byte never produces a response beat
   a_rx_silent: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_op == OP_RX_BYTE) |=> !rsp_valid)
      else $error("response beat after received byte");

   // a line read always occupies the block
   a_read_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_op == OP_READ_LINE) |=> busy)
      else $error("line read did not raise busy");

   // data beats come only during a read and carry no summary
   a_data_beat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> (busy && rsp_count == '0 && !rsp_got_data))
      else $error("malformed data beat");

   // a read ends exactly with its terminator
   a_end_term: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> (rsp_valid && rsp_last))
      else $error("busy dropped without terminator");

   // got_data agrees with count on the terminator
   a_term_got: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> (rsp_got_data == (rsp_count != '0)))
      else $error("terminator flag mismatch");

endmodule

bind rx_ring_line_reader_unit rrlr_checker u_rrlr_checker (.*);

FILE: test/line_read_checker.sv
// line_read_checker: watches the request and response channels of the ring
// line reader, keeps its own copy of the ring and checks every response beat.
// Depends on rrlr_pkg.
`timescale 1ns / 1ps

module line_read_checker
   import rrlr_pkg::*;
#(
   parameter int RING_DEPTH = 256,
   parameter int MAX_READ   = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  logic              req_op,
   input  logic [DATA_W-1:0] req_rx_byte,
   input  logic [LEN_W-1:0]  req_max_len,
   input  logic              rsp_valid,
   input  logic [DATA_W-1:0] rsp_data_byte,
   input  logic              rsp_last,
   input  logic [CNT_W-1:0]  rsp_count,
   input  logic              rsp_got_data,
   output int                mismatches,
   output int                waiting,
   output int                beats_checked
);

   typedef struct packed {
      logic [DATA_W-1:0] data_byte;
      logic              last;
      logic [CNT_W-1:0]  count;
      logic              got_data;
   } line_beat_t;

   logic [DATA_W-1:0] ring_copy [RING_DEPTH];
   int                wr_idx;
   int                rd_idx;
   line_beat_t        line_queue [$];
   line_beat_t        seen;
   line_beat_t        want;

   function automatic int ring_step(input int p);
      return (p + 1 == RING_DEPTH) ? 0 : p + 1;
   endfunction

   function automatic line_beat_t make_beat(input logic [DATA_W-1:0] d, input logic l,
                                            input logic [CNT_W-1:0] c, input logic g);
      line_beat_t b;
      b.data_byte = d;
      b.last      = l;
      b.count     = c;
      b.got_data  = g;
      return b;
   endfunction

   // store unless that would close the one free slot
   task automatic store_rx(input logic [DATA_W-1:0] b);
      if (ring_step(wr_idx) != rd_idx) begin
         ring_copy[wr_idx] = b;
         wr_idx = ring_step(wr_idx);
      end
   endtask

   // pop up to limit-1 bytes, stop on empty or after a newline, then terminator
   task automatic predict_line(input logic [LEN_W-1:0] len);
      int                lim;
      int                n;
      logic              hit_nl;
      logic [DATA_W-1:0] c;
      lim    = (int'(len) > MAX_READ) ? MAX_READ : int'(len);
      n      = 0;
      hit_nl = 1'b0;
      while (lim > 0 && !hit_nl && rd_idx != wr_idx && n < lim - 1) begin
         c = ring_copy[rd_idx];
         rd_idx = ring_step(rd_idx);
         line_queue.push_back(make_beat(c, 1'b0, '0, 1'b0));
         n++;
         hit_nl = (c == NEWLINE_CODE);
      end
      line_queue.push_back(make_beat('0, 1'b1, CNT_W'(n), n > 0));
   endtask

   task automatic flag(input string what);
      mismatches++;
      if (mismatches <= 10)
         $display({"tb: %s: want data %h last %b count %0d got_data %b,",
                   " saw data %h last %b count %0d got_data %b"},
                  what, want.data_byte, want.last, want.count, want.got_data,
                  seen.data_byte, seen.last, seen.count, seen.got_data);
   endtask

   // requests are predicted before responses are compared on the same edge
   always @(posedge clock) begin
      if (reset) begin
         wr_idx        = 0;
         rd_idx        = 0;
         mismatches    = 0;
         beats_checked = 0;
         line_queue.delete();
      end else begin
         if (start && !busy) begin
            if (req_op == OP_READ_LINE)
               predict_line(req_max_len);
            else
               store_rx(req_rx_byte);
         end
         if (rsp_valid) begin
            seen = make_beat(rsp_data_byte, rsp_last, rsp_count, rsp_got_data);
            if (line_queue.size() == 0) begin
               want = '0;
               flag("response beat with none expected");
            end else begin
               want = line_queue.pop_front();
               if (seen.data_byte !== want.data_byte || seen.last !== want.last ||
                   seen.count !== want.count || seen.got_data !== want.got_data)
                  flag("mismatch");
            end
            beats_checked++;
         end
      end
      waiting = line_queue.size();
   end

endmodule

FILE: test/tb.sv
// tb: top of the ring line reader bench; drives request beats and gives the verdict.
// Depends on rrlr_pkg, rx_ring_line_reader_unit and line_read_checker.
`timescale 1ns / 1ps

module tb;
   import rrlr_pkg::*;

   localparam int RING_DEPTH  = 256;
   localparam int MAX_READ    = 64;
   localparam int ITEM_GOAL   = 480;
   localparam int CYCLE_LIMIT = 400_000;
   localparam int DRAIN_LIMIT = 5000;
   localparam int SETTLE      = 40;        // quiet margin once the last read is done

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              start       = 1'b0;
   logic              busy;
   logic              req_op      = OP_RX_BYTE;
   logic [DATA_W-1:0] req_rx_byte = '0;
   logic [LEN_W-1:0]  req_max_len = '0;
   logic              rsp_valid;
   logic [DATA_W-1:0] rsp_data_byte;
   logic              rsp_last;
   logic [CNT_W-1:0]  rsp_count;
   logic              rsp_got_data;

   int   line_errors;
   int   line_waiting;
   int   line_beats;
   int   items_sent = 0;
   int   reads_sent = 0;
   int   cycles     = 0;
   logic gaps_on    = 1'b1;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   rx_ring_line_reader_unit #(
      .RING_DEPTH (RING_DEPTH),
      .MAX_READ   (MAX_READ)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_op        (req_op),
      .req_rx_byte   (req_rx_byte),
      .req_max_len   (req_max_len),
      .rsp_valid     (rsp_valid),
      .rsp_data_byte (rsp_data_byte),
      .rsp_last      (rsp_last),
      .rsp_count     (rsp_count),
      .rsp_got_data  (rsp_got_data)
   );

   line_read_checker #(
      .RING_DEPTH (RING_DEPTH),
      .MAX_READ   (MAX_READ)
   ) chk (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_op        (req_op),
      .req_rx_byte   (req_rx_byte),
      .req_max_len   (req_max_len),
      .rsp_valid     (rsp_valid),
      .rsp_data_byte (rsp_data_byte),
      .rsp_last      (rsp_last),
      .rsp_count     (rsp_count),
      .rsp_got_data  (rsp_got_data),
      .mismatches    (line_errors),
      .waiting       (line_waiting),
      .beats_checked (line_beats)
   );

   // hard stop in case the block hangs
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("tb: cycle limit reached, %0d response beats still due", line_waiting);
         $display("tb: done, errors");
         $finish;
      end
   end

   // random byte that is never a newline, so lines end only where we say
   function automatic logic [DATA_W-1:0] plain_byte();
      logic [DATA_W-1:0] b;
      b = DATA_W'($urandom);
      return (b == NEWLINE_CODE) ? 8'h0B : b;
   endfunction

   // mostly legal limits, some at zero/one, some past MAX_READ (saturates)
   function automatic logic [LEN_W-1:0] pick_limit();
      int r;
      r = $urandom_range(99);
      if (r < 10)
         return LEN_W'($urandom_range(1));
      else if (r < 20)
         return LEN_W'($urandom_range(127, MAX_READ + 1));
      else
         return LEN_W'($urandom_range(MAX_READ, 2));
   endfunction

   // One request beat. Optional idle cycles first, then hold start until busy is
   // low at an edge. Values read right after the edge are the pre-edge ones.
   // The unused field of each beat carries noise.
   task automatic send_beat(input logic op, input logic [DATA_W-1:0] b,
                            input logic [LEN_W-1:0] len);
      while (gaps_on && $urandom_range(99) < 15) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start       <= 1'b1;
      req_op      <= op;
      req_rx_byte <= (op == OP_RX_BYTE) ? b : DATA_W'($urandom);
      req_max_len <= (op == OP_READ_LINE) ? len : LEN_W'($urandom);
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
      if (op == OP_READ_LINE) reads_sent++;
   endtask

   initial begin
      int   pick;
      int   drain;
      logic flooded;
      flooded = 1'b0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed ---
      send_beat(OP_READ_LINE, '0, 7'd5);          // read on empty ring: terminator only
      send_beat(OP_RX_BYTE, 8'h00, '0);
      send_beat(OP_RX_BYTE, 8'hFF, '0);
      send_beat(OP_RX_BYTE, NEWLINE_CODE, '0);
      send_beat(OP_RX_BYTE, 8'h55, '0);
      send_beat(OP_RX_BYTE, 8'hAA, '0);
      send_beat(OP_RX_BYTE, 8'h41, '0);
      send_beat(OP_READ_LINE, '0, 7'd0);          // limit zero, data waiting
      send_beat(OP_READ_LINE, '0, 7'd1);          // limit one acts like zero
      send_beat(OP_READ_LINE, '0, 7'd64);         // stops after the newline
      send_beat(OP_READ_LINE, '0, 7'd127);        // saturated limit, stops on empty
      repeat (8) send_beat(OP_RX_BYTE, plain_byte(), '0);
      send_beat(OP_READ_LINE, '0, 7'd4);          // stops on limit, 3 bytes
      send_beat(OP_READ_LINE, '0, 7'd65);         // rest of the ring
      send_beat(OP_READ_LINE, '0, 7'd2);          // empty again

      // --- random ---
      while (items_sent < ITEM_GOAL) begin
         gaps_on = !(items_sent >= 40 && items_sent < 110);   // long gap-free stretch
         if (!flooded && items_sent >= 90) begin
            flooded = 1'b1;
            // overfill so the last beats land on a full ring and get dropped,
            // then drain with max-size reads (up to 63 bytes each)
            repeat (RING_DEPTH + 4) send_beat(OP_RX_BYTE, plain_byte(), '0);
            repeat (5) send_beat(OP_READ_LINE, '0, LEN_W'(MAX_READ));
         end
         pick = $urandom_range(99);
         if (pick < 60) begin
            // well-formed traffic: a few newline-terminated lines, then reads
            repeat ($urandom_range(3, 1)) begin
               repeat ($urandom_range(20, 0)) send_beat(OP_RX_BYTE, plain_byte(), '0);
               send_beat(OP_RX_BYTE, NEWLINE_CODE, '0);
            end
            repeat ($urandom_range(4, 1)) send_beat(OP_READ_LINE, '0, pick_limit());
         end else if (pick < 85) begin
            // noise: any op, any byte (newlines included), any limit
            repeat ($urandom_range(8, 1))
               send_beat(1'($urandom_range(1)), DATA_W'($urandom), pick_limit());
         end else begin
            repeat ($urandom_range(3, 1)) send_beat(OP_READ_LINE, '0, pick_limit());
         end
      end
      start <= 1'b0;
      // one edge so busy reflects the last accepted beat
      @(posedge clock);

      // wait out the last read, bounded
      drain = 0;
      while ((line_waiting != 0 || busy) && drain < DRAIN_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      repeat (SETTLE) @(posedge clock);

      $display("tb: %0d request beats sent (%0d line reads, ring filled past capacity once)",
               items_sent, reads_sent);
      $display("tb: %0d response beats checked, %0d mismatches, %0d never arrived",
               line_beats, line_errors, line_waiting);
      if (line_errors == 0 && line_waiting == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule
